// ===== hdl/u8ucs2_pkg.sv =====
// types and constants for the utf-8 to ucs-2 string descriptor encoder
// no dependencies; imported by the encoder top level and its checker
package u8ucs2_pkg;

   // status codes carried on the final response of a string
   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_INVALID_LEAD = 3'd1;
   localparam logic [2:0] STATUS_ZERO_POINT   = 3'd2;
   localparam logic [2:0] STATUS_TRUNCATED    = 3'd3;
   localparam logic [2:0] STATUS_BUFFER_FULL  = 3'd4;

   // register map, register index taken from the word address
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam logic        CSR_IDX_MAX_UNITS = 1'b0;
   localparam logic [6:0]  MAX_UNITS_RESET = 7'd126;

   // utf-8 lead and continuation byte payload masks
   localparam logic [7:0] LEAD2_MASK = 8'h1F;
   localparam logic [7:0] LEAD3_MASK = 8'h0F;
   localparam logic [7:0] LEAD4_MASK = 8'h07;
   localparam logic [7:0] CONT_MASK  = 8'h3F;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic        unit_valid;
      logic [15:0] code_unit;
      logic [7:0]  descriptor_length;
      logic [2:0]  status;
      logic        last;
   } rsp_payload_type;

endpackage

// ===== hdl/utf8_to_ucs2_string_encoder.sv =====
// utf-8 to ucs-2 string descriptor encoder, one byte per request
// a response is registered in the output register, or in the skid register if that is stalled
// throughput: one request per cycle while req_stall is low; a skid register takes one more response while
//    the output register is stalled, and req_stall rises only when the skid is full
// reset: synchronous; clears string state and both response slots, max_units to 126
module utf8_to_ucs2_string_encoder #(
   parameter int unsigned BUFFER_BYTES = 255
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  u8ucs2_pkg::req_payload_type              req_payload,
   // response channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output u8ucs2_pkg::rsp_payload_type              rsp_payload,
   // register port
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [u8ucs2_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [31:0]                              csr_pwdata,
   output logic [31:0]                              csr_prdata,
   output logic                                     csr_pready
);
   import u8ucs2_pkg::*;

   // largest unit count the descriptor buffer can hold
   localparam int unsigned ROOM_UNITS = (BUFFER_BYTES - 2) / 2;
   localparam logic [6:0]  ROOM = 7'(ROOM_UNITS);

   logic [6:0]       max_units_ff;
   logic [1:0]       pend_ff, pend_in;
   logic [20:0]      part_ff, part_in;
   logic [6:0]       units_ff, units_in;
   logic             stop_ff, stop_in;
   logic [2:0]       stat_ff, stat_in;

   logic             out_valid_ff, out_valid_in;
   rsp_payload_type  out_ff, out_in;
   logic             skid_valid_ff, skid_valid_in;
   rsp_payload_type  skid_ff, skid_in;

   logic             req_take;
   logic             rsp_take;
   logic             csr_write;
   logic [6:0]       cap;
   logic [7:0]       b;
   logic             eos;
   logic             done;
   logic             emit;
   logic [20:0]      cp;
   logic             res_valid;
   rsp_payload_type  res;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_MAX_UNITS);
   assign csr_prdata = (csr_paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_MAX_UNITS)
                       ? {25'd0, max_units_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_units_ff <= MAX_UNITS_RESET;
      end else if (csr_write) begin
         max_units_ff <= csr_pwdata[6:0];
      end
   end

   // handshakes
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign rsp_payload = out_ff;

   assign cap = (max_units_ff > ROOM) ? ROOM : max_units_ff;
   assign b   = req_payload.in_byte;
   assign eos = req_payload.end_of_string;

   // byte decode and string state update
   always_comb begin
      pend_in  = pend_ff;
      part_in  = part_ff;
      units_in = units_ff;
      stop_in  = stop_ff;
      stat_in  = stat_ff;
      done     = 1'b0;
      emit     = 1'b0;
      cp       = 21'd0;
      if (!stop_ff) begin
         if (pend_ff == 2'd0) begin
            case (b) inside
               8'b0???????: begin
                  cp   = {13'd0, b};
                  done = 1'b1;
               end
               8'b110?????: begin
                  part_in = {13'd0, b & LEAD2_MASK};
                  pend_in = 2'd1;
               end
               8'b1110????: begin
                  part_in = {13'd0, b & LEAD3_MASK};
                  pend_in = 2'd2;
               end
               8'b11110???: begin
                  part_in = {13'd0, b & LEAD4_MASK};
                  pend_in = 2'd3;
               end
               default: begin
                  stop_in = 1'b1;
                  stat_in = STATUS_INVALID_LEAD;
                  pend_in = 2'd0;
                  part_in = 21'd0;
               end
            endcase
         end else begin
            part_in = {part_ff[14:0], b[5:0] & CONT_MASK[5:0]};
            pend_in = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               cp      = part_in;
               part_in = 21'd0;
               done    = 1'b1;
            end
         end

         // finished character: zero check, capacity check, emit
         if (done) begin
            if (cp == 21'd0) begin
               stop_in = 1'b1;
               stat_in = STATUS_ZERO_POINT;
               pend_in = 2'd0;
               part_in = 21'd0;
            end else if (units_ff >= cap) begin
               stop_in = 1'b1;
               stat_in = STATUS_BUFFER_FULL;
               pend_in = 2'd0;
               part_in = 21'd0;
            end else begin
               units_in = units_ff + 7'd1;
               emit     = 1'b1;
            end
         end

         // end mark in the middle of a sequence
         if (eos && !stop_in && pend_in != 2'd0) begin
            stop_in = 1'b1;
            stat_in = STATUS_TRUNCATED;
            pend_in = 2'd0;
            part_in = 21'd0;
         end
      end

      res_valid              = eos || emit;
      res.unit_valid         = emit;
      res.code_unit          = emit ? cp[15:0] : 16'd0;
      res.descriptor_length  = 8'd2 + {units_in, 1'b0};
      res.status             = (eos && stop_in) ? stat_in : STATUS_OK;
      res.last               = eos;

      // end of string returns string state to zero
      if (eos) begin
         pend_in  = 2'd0;
         part_in  = 21'd0;
         units_in = 7'd0;
         stop_in  = 1'b0;
         stat_in  = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 2'd0;
         part_ff  <= 21'd0;
         units_ff <= 7'd0;
         stop_ff  <= 1'b0;
         stat_ff  <= STATUS_OK;
      end else if (req_take) begin
         pend_ff  <= pend_in;
         part_ff  <= part_in;
         units_ff <= units_in;
         stop_ff  <= stop_in;
         stat_ff  <= stat_in;
      end
   end

   // output register and skid slot
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take && res_valid) begin
         if (!out_valid_ff || rsp_take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== hdl/u8ucs2_checker.sv =====
// port-level checks for the utf-8 to ucs-2 string descriptor encoder
// depends on u8ucs2_pkg; bound to utf8_to_ucs2_string_encoder below
module u8ucs2_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_stall,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  u8ucs2_pkg::rsp_payload_type   rsp_payload
);
   import u8ucs2_pkg::*;

   // request side only backs up when a response is waiting
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // a response that is not the last one carries a unit and ok status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> rsp_payload.unit_valid
                                          && rsp_payload.status == STATUS_OK)
      else $error("non-final response without unit or with error status");

   // descriptor length is even and at least 2
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_payload.descriptor_length[0]
                    && rsp_payload.descriptor_length != 8'd0)
      else $error("bad descriptor length");

   // an emitted unit is already counted in the descriptor length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.unit_valid |-> rsp_payload.descriptor_length >= 8'd4)
      else $error("unit emitted with no count");

endmodule

bind utf8_to_ucs2_string_encoder u8ucs2_checker u_u8ucs2_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
